// ===== hdl/alfs_pkg.sv =====
`timescale 1ns / 1ps
// alfs_pkg: shared types and constants of the access log field splitter
// no dependencies; imported by access_log_field_splitter_unit
package alfs_pkg;

  // width of the status and size value, saturating at all ones
  localparam int unsigned NUMBER_BITS = 31;

  // field numbering
  localparam logic [3:0] FIELD_DATE    = 4'd3;
  localparam logic [3:0] FIELD_REQUEST = 4'd4;
  localparam logic [3:0] FIELD_STATUS  = 4'd5;
  localparam logic [3:0] FIELD_SIZE    = 4'd6;
  localparam logic [3:0] FIELD_COUNT   = 4'd9;

  // delimiter characters
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
  localparam logic [7:0] CHAR_LBRACKET  = 8'h5b;
  localparam logic [7:0] CHAR_RBRACKET  = 8'h5d;
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_DASH      = 8'h2d;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_NINE      = 8'h39;

  // error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_OPEN       = 2'd1;
  localparam logic [1:0] ERR_UNTERM     = 2'd2;
  localparam logic [1:0] ERR_NOT_NUMBER = 2'd3;

  // input transaction
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_line;
  } alfs_in_t;

  // result transaction
  typedef struct packed {
    logic [3:0]             field_index;
    logic [7:0]             data_byte;
    logic                   data_valid;
    logic                   field_end;
    logic                   field_absent;
    logic [NUMBER_BITS-1:0] number_value;
    logic                   line_end;
    logic [3:0]             fields_parsed;
    logic [1:0]             error_code;
  } alfs_out_t;

endpackage

// ===== hdl/access_log_field_splitter_unit.sv =====
`timescale 1ns / 1ps
// access_log_field_splitter_unit: splits one access-log line, a byte per
// transaction, into nine fields; depends on alfs_pkg
//
// channel | direction | payload    | handshake
// in      | input     | alfs_in_t  | in_valid_i / in_ready_o
// out     | output    | alfs_out_t | out_valid_o / out_ready_i
//
// One byte is accepted per cycle when not stalled; any result it forms
// appears in the output register on the next cycle. The parse state and
// result register update in the same edge; unstalled, one byte per clock.
// While a result is held and out_ready_i is low, in_ready_o drops.
// Reset returns the parser to the start of a line with no result pending.
module access_log_field_splitter_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  alfs_pkg::alfs_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output alfs_pkg::alfs_out_t out_data_o
);
  import alfs_pkg::*;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_TOKEN,
    PH_STRING,
    PH_DONE,
    PH_ERROR
  } phase_e;

  localparam int unsigned MacBits = NUMBER_BITS + 4;
  localparam logic [NUMBER_BITS-1:0] NumMax = {NUMBER_BITS{1'b1}};

  phase_e                 phase_q, phase_d;
  logic [3:0]             field_q, field_d;
  logic [7:0]             prev_q, prev_d;
  logic                   dash_q, dash_d;
  logic                   longer_q, longer_d;
  logic [NUMBER_BITS-1:0] acc_q, acc_d;
  logic [1:0]             err_q, err_d;
  logic                   out_valid_q;
  alfs_out_t              out_q;
  alfs_out_t              res;
  logic                   have;
  logic                   accept;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // parse one byte and form its result
  always_comb begin
    logic [7:0]             b;
    logic                   eol;
    logic                   is_ws;
    logic                   is_num;
    logic                   is_digit;
    logic                   take;
    logic                   close;
    logic [7:0]             opener;
    logic [7:0]             closer;
    logic [MacBits-1:0]     mac;
    phase_e                 ph;
    logic [3:0]             fld;
    logic                   fwd;
    logic                   lto;
    logic [NUMBER_BITS-1:0] acc;
    logic [1:0]             err;

    b        = in_data_i.in_byte;
    eol      = in_data_i.end_of_line;
    is_ws    = (b == CHAR_SPACE) || (b == CHAR_TAB);
    is_num   = (field_q == FIELD_STATUS) || (field_q == FIELD_SIZE);
    is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    opener   = (field_q == FIELD_DATE) ? CHAR_LBRACKET : CHAR_QUOTE;
    closer   = (field_q == FIELD_DATE) ? CHAR_RBRACKET : CHAR_QUOTE;
    ph       = phase_q;
    fld      = field_q;
    fwd      = dash_q;
    lto      = longer_q;
    acc      = acc_q;
    err      = err_q;
    take     = 1'b0;
    close    = 1'b0;
    have     = 1'b0;
    res      = '0;
    res.field_index = field_q;

    // byte handling per phase
    unique case (phase_q)
      PH_SKIP: begin
        if (!is_ws) begin
          if ((field_q == FIELD_DATE) || (field_q == FIELD_REQUEST)) begin
            if (b == opener) begin
              fwd = 1'b0;
              lto = 1'b0;
              acc = '0;
              ph  = PH_STRING;
            end else begin
              err  = ERR_OPEN;
              ph   = PH_ERROR;
              have = 1'b1;
            end
          end else begin
            fwd  = 1'b0;
            lto  = 1'b0;
            acc  = '0;
            err  = ERR_NONE;
            ph   = PH_TOKEN;
            take = 1'b1;
          end
        end
      end
      PH_TOKEN: begin
        if (is_ws) begin
          close = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
      PH_STRING: begin
        if ((b == closer) && (prev_q != CHAR_BACKSLASH)) begin
          close = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // content byte: dash tracking and decimal accumulation
    mac = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + MacBits'(b[3:0]);
    if (take) begin
      have            = 1'b1;
      res.data_valid  = 1'b1;
      res.data_byte   = b;
      if (fwd || lto) begin
        lto = 1'b1;
      end else if (b == CHAR_DASH) begin
        fwd = 1'b1;
      end else begin
        lto = 1'b1;
      end
      if (is_num) begin
        if (is_digit) begin
          if (mac > {4'b0, NumMax}) begin
            acc = NumMax;
          end else begin
            acc = mac[NUMBER_BITS-1:0];
          end
        end else if (err == ERR_NONE) begin
          err = ERR_NOT_NUMBER;
        end
      end
    end

    // a token still open at line end closes with it
    if (eol && (ph == PH_TOKEN)) begin
      close = 1'b1;
    end

    // field close
    if (close) begin
      have             = 1'b1;
      res.field_end    = 1'b1;
      res.field_absent = fwd && !lto;
      if (is_num && !(fwd && !lto) && (err == ERR_NOT_NUMBER)) begin
        ph = PH_ERROR;
      end else begin
        if (is_num) begin
          if (fwd && !lto) begin
            err = ERR_NONE;
          end else begin
            res.number_value = acc;
          end
        end
        fld = fld + 4'd1;
        ph  = (fld >= FIELD_COUNT) ? PH_DONE : PH_SKIP;
      end
    end

    // line end checks
    if (eol) begin
      have         = 1'b1;
      res.line_end = 1'b1;
      if (ph == PH_STRING) begin
        err = ERR_UNTERM;
        ph  = PH_ERROR;
      end
      if ((ph == PH_SKIP) && (fld <= FIELD_REQUEST)) begin
        err = ERR_OPEN;
        ph  = PH_ERROR;
      end
      res.fields_parsed = fld;
    end

    res.error_code = (ph == PH_ERROR) ? err : ERR_NONE;

    // next state, back to line start after the final byte
    if (eol) begin
      phase_d  = PH_SKIP;
      field_d  = '0;
      prev_d   = '0;
      dash_d   = 1'b0;
      longer_d = 1'b0;
      acc_d    = '0;
      err_d    = ERR_NONE;
    end else begin
      phase_d  = ph;
      field_d  = fld;
      prev_d   = b;
      dash_d   = fwd;
      longer_d = lto;
      acc_d    = acc;
      err_d    = err;
    end
  end

  // parse state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SKIP;
      field_q     <= '0;
      prev_q      <= '0;
      dash_q      <= 1'b0;
      longer_q    <= 1'b0;
      acc_q       <= '0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (accept) begin
        phase_q     <= phase_d;
        field_q     <= field_d;
        prev_q      <= prev_d;
        dash_q      <= dash_d;
        longer_q    <= longer_d;
        acc_q       <= acc_d;
        err_q       <= err_d;
        out_valid_q <= have;
        if (have) begin
          out_q <= res;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
